// File: rtl/core/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/core/bmbe_pkg.sv
`default_nettype none

package bmbe_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // result queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = 2;
  localparam int unsigned OQ_CNT_W = 3;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   is_edge;
    coord_t pixel_col;
    coord_t pixel_row;
    logic   last_of_run;
    logic   frame_done;
    logic   box_valid;
    coord_t box_min_col;
    coord_t box_max_col;
    coord_t box_min_row;
    coord_t box_max_row;
  } res_t;

  // up to two results written per accepted pixel
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } oq_wr_t;

  // one column of the two line stores: a = row above, b = two rows above
  typedef struct packed {
    logic a;
    logic b;
  } cell_t;

endpackage

`default_nettype wire

// File: rtl/core/bmbe_if.sv
`default_nettype none

interface bmbe_pix_if import bmbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] mask_pixel;

  modport source (output valid, output mask_pixel, input ready);
  modport sink   (input valid, input mask_pixel, output ready);
endinterface

interface bmbe_res_if import bmbe_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   is_edge;
  coord_t pixel_col;
  coord_t pixel_row;
  logic   last_of_run;
  logic   frame_done;
  logic   box_valid;
  coord_t box_min_col;
  coord_t box_max_col;
  coord_t box_min_row;
  coord_t box_max_row;

  modport source (
    output valid, output is_edge, output pixel_col, output pixel_row,
    output last_of_run, output frame_done, output box_valid,
    output box_min_col, output box_max_col, output box_min_row, output box_max_row,
    input ready
  );
  modport sink (
    input valid, input is_edge, input pixel_col, input pixel_row,
    input last_of_run, input frame_done, input box_valid,
    input box_min_col, input box_max_col, input box_min_row, input box_max_row,
    output ready
  );
endinterface

interface bmbe_cfg_if import bmbe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bmbe_cell.sv
`default_nettype none

module bmbe_cell import bmbe_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  logic  head_i,
  input  cell_t new_i,
  input  cell_t prev_i,
  output cell_t q_o
);

  cell_t flag_q, flag_d;

  // the head cell takes the new column, every other one its neighbor
  assign flag_d = head_i ? new_i : prev_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flag_q <= flag_d;
    end
  end

  assign q_o = flag_q;

endmodule

`default_nettype wire

// File: rtl/core/bmbe_line.sv
`default_nettype none

module bmbe_line import bmbe_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] head_i,
  input  logic                         pix_flag_i,
  output logic                         ctr_o,
  output logic                         rgt_o,
  output logic                         up_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  cell_t chain [MAX_WIDTH];
  cell_t feed;

  // row above feeds the store of two rows above as it leaves
  assign feed.a = pix_flag_i;
  assign feed.b = chain[MAX_WIDTH-1].a;

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    cell_t prev;
    if (k == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = chain[k-1];
    end

    bmbe_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .head_i (head_i == CW'(k)),
      .new_i  (feed),
      .prev_i (prev),
      .q_o    (chain[k])
    );
  end

  // tail holds the pixel one row back, the cell before it one column further
  assign ctr_o = chain[MAX_WIDTH-1].a;
  assign rgt_o = chain[MAX_WIDTH-2].a;
  assign up_o  = chain[MAX_WIDTH-1].b;

endmodule

`default_nettype wire

// File: rtl/core/bmbe_outq.sv
`default_nettype none
`include "assert_macros.svh"

module bmbe_outq import bmbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oq_wr_t            wr_i,
  output logic              room_o,
  bmbe_res_if.source        res_o
);

  res_t                slot_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                pop;
  res_t                head;

  assign pop = res_o.valid & res_o.ready;

  always_comb begin
    wp_d  = wp_q + OQ_PTR_W'(wr_i.num);
    rp_d  = rp_q + OQ_PTR_W'(pop);
    cnt_d = cnt_q + OQ_CNT_W'(wr_i.num) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.num != 2'd0) begin
      slot_q[wp_q] <= wr_i.first;
    end
    if (wr_i.num == 2'd2) begin
      slot_q[wp_q + OQ_PTR_W'(1)] <= wr_i.second;
    end
  end

  // room for a worst-case pixel (two results) regardless of this cycle's transfer
  assign room_o = cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2);

  assign head              = slot_q[rp_q];
  assign res_o.valid       = cnt_q != '0;
  assign res_o.is_edge     = head.is_edge;
  assign res_o.pixel_col   = head.pixel_col;
  assign res_o.pixel_row   = head.pixel_row;
  assign res_o.last_of_run = head.last_of_run;
  assign res_o.frame_done  = head.frame_done;
  assign res_o.box_valid   = head.box_valid;
  assign res_o.box_min_col = head.box_min_col;
  assign res_o.box_max_col = head.box_max_col;
  assign res_o.box_min_row = head.box_min_row;
  assign res_o.box_max_row = head.box_max_row;

  `ASSERT_IMPL(a_oq_no_overflow, clk_i, rst_ni, wr_i.num != 2'd0, cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2), "result queue written without room")
  `ASSERT_IMPL(a_oq_ptr_match, clk_i, rst_ni, cnt_q != OQ_CNT_W'(OQ_DEPTH), OQ_PTR_W'(cnt_q) == OQ_PTR_W'(wp_q - rp_q), "result queue pointers disagree with count")
  `ASSERT_RST(a_oq_count, clk_i, rst_ni, (wr_i.num == 2'd0) && !pop |=> $stable(cnt_q), "result queue count moved without transfer")

endmodule

`default_nettype wire

// File: rtl/core/binary_mask_boundary_extract.sv
// 4-neighbour boundary extraction on a raster mask, one pixel per clock while the result
// queue has room and no register write is pending. A verdict is queued at the transfer
// of the pixel below (frame_width pixels later) and then offered from the result queue;
// last-row pixels are queued at their own transfer. Last-row pixels give two results;
// elsewhere the 4-entry result queue keeps one pixel per clock while results are taken.
// reset clears counters, bounding box and queue and sets both sizes to min(max, 1024).
`default_nettype none
`include "assert_macros.svh"

module binary_mask_boundary_extract import bmbe_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmbe_cfg_if.sink    cfg_i,
  bmbe_pix_if.sink    pix_i,
  bmbe_res_if.source  res_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned W_RST = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int unsigned H_RST = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

  typedef struct packed {
    logic          v;
    logic [CW-1:0] cmin;
    logic [CW-1:0] cmax;
    logic [RW-1:0] rmin;
    logic [RW-1:0] rmax;
  } bbox_t;

  function automatic bbox_t bbox_add(bbox_t b, logic e, logic [CW-1:0] c, logic [RW-1:0] r);
    bbox_t n;
    n = b;
    if (e) begin
      if (!b.v) begin
        n.v    = 1'b1;
        n.cmin = c;
        n.cmax = c;
        n.rmin = r;
        n.rmax = r;
      end else begin
        if (c < b.cmin) n.cmin = c;
        if (c > b.cmax) n.cmax = c;
        if (r < b.rmin) n.rmin = r;
        if (r > b.rmax) n.rmax = r;
      end
    end
    return n;
  endfunction

  function automatic res_t mk_res(bbox_t b, logic e, logic [CW-1:0] c, logic [RW-1:0] r,
                                  logic last, logic done);
    res_t o;
    o.is_edge     = e;
    o.pixel_col   = COORD_W'(c);
    o.pixel_row   = COORD_W'(r);
    o.last_of_run = last;
    o.frame_done  = done;
    o.box_valid   = b.v;
    o.box_min_col = COORD_W'(b.cmin);
    o.box_max_col = COORD_W'(b.cmax);
    o.box_min_row = COORD_W'(b.rmin);
    o.box_max_row = COORD_W'(b.rmax);
    return o;
  endfunction

  // configuration
  logic [WW-1:0] w_q, w_cfg;
  logic [HW-1:0] h_q, h_cfg;
  logic [CW-1:0] hd_q, hd_cfg;
  logic          cfg_we;

  // frame position and neighbor state
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          left_q, left_d;
  bbox_t         box_q, box_d;

  logic          acc, cur, last_col, last_row, has1, on_frame, edge1;
  logic          ctr, rgt, up;
  logic [WW-1:0] col_nx;
  logic [HW-1:0] row_nx;
  logic [RW-1:0] row_up;
  bbox_t         box0, box1;
  res_t          res1, res2;
  oq_wr_t        wr;
  logic          room;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid & cfg_i.ready;

  // sizes saturate to 1..max
  always_comb begin
    if (cfg_i.wdata == '0) begin
      w_cfg = WW'(1);
    end else if (32'(cfg_i.wdata) > MAX_WIDTH) begin
      w_cfg = WW'(MAX_WIDTH);
    end else begin
      w_cfg = WW'(cfg_i.wdata);
    end
    if (cfg_i.wdata == '0) begin
      h_cfg = HW'(1);
    end else if (32'(cfg_i.wdata) > MAX_HEIGHT) begin
      h_cfg = HW'(MAX_HEIGHT);
    end else begin
      h_cfg = HW'(cfg_i.wdata);
    end
    hd_cfg = CW'(MAX_WIDTH - 32'(w_cfg));
  end

  assign acc = pix_i.valid & pix_i.ready;
  assign cur = |pix_i.mask_pixel;

  bmbe_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk_i      (clk_i),
    .en_i       (acc),
    .head_i     (hd_q),
    .pix_flag_i (cur),
    .ctr_o      (ctr),
    .rgt_o      (rgt),
    .up_o       (up)
  );

  always_comb begin
    col_nx   = WW'(col_q) + WW'(1);
    row_nx   = HW'(row_q) + HW'(1);
    row_up   = row_q - RW'(1);
    last_col = col_nx >= w_q;
    last_row = row_nx >= h_q;
    has1     = row_q != '0;
    on_frame = (row_q == RW'(1)) || (col_q == '0) || last_col || (HW'(row_q) >= h_q);
    edge1    = ctr & (on_frame | ~up | ~cur | ~left_q | ~rgt);

    // bounding box restarts with the first pixel of a frame
    box0 = ((row_q == '0) && (col_q == '0)) ? '0 : box_q;
    box1 = has1 ? bbox_add(box0, edge1, col_q, row_up) : box0;
    box_d = last_row ? bbox_add(box1, cur, col_q, row_q) : box1;

    res1 = mk_res(box1, edge1, col_q, row_up, ~last_row,
                  (HW'(row_q) >= h_q) & last_col);
    res2 = mk_res(box_d, cur, col_q, row_q, 1'b1, last_col);

    wr.num    = acc ? (2'(has1) + 2'(last_row)) : 2'd0;
    wr.first  = has1 ? res1 : res2;
    wr.second = res2;

    left_d = has1 ? ctr : left_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : RW'(row_nx);
    end else begin
      col_d = CW'(col_nx);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= WW'(W_RST);
      h_q    <= HW'(H_RST);
      hd_q   <= CW'(MAX_WIDTH - W_RST);
      col_q  <= '0;
      row_q  <= '0;
      left_q <= 1'b0;
      box_q  <= '0;
    end else if (cfg_we) begin
      if (cfg_i.idx == REG_FRAME_WIDTH) begin
        w_q  <= w_cfg;
        hd_q <= hd_cfg;
      end
      if (cfg_i.idx == REG_FRAME_HEIGHT) begin
        h_q <= h_cfg;
      end
      // any known register restarts the frame
      if ((cfg_i.idx == REG_FRAME_WIDTH) || (cfg_i.idx == REG_FRAME_HEIGHT)) begin
        col_q  <= '0;
        row_q  <= '0;
        left_q <= 1'b0;
      end
    end else if (acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
      box_q  <= box_d;
    end
  end

  bmbe_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .room_o (room),
    .res_o  (res_o)
  );

  // a pending register write holds off pixel transfers
  assign pix_i.ready = room & ~cfg_i.valid;

  `ASSERT_IMPL(a_edge_in_box, clk_i, rst_ni, res_o.valid && res_o.is_edge, res_o.box_valid, "boundary pixel reported outside a valid box")
  `ASSERT_IMPL(a_box_order, clk_i, rst_ni, box_q.v, (box_q.cmin <= box_q.cmax) && (box_q.rmin <= box_q.rmax), "bounding box corners crossed")
  `ASSERT_RST(a_pos_in_frame, clk_i, rst_ni, (WW'(col_q) < w_q) && (HW'(row_q) < h_q), "pixel position outside frame")

endmodule

`default_nettype wire
